[rtl/core/rlesd_pkg.sv]
`default_nettype none

package rlesd_pkg;

  // Field widths
  localparam int unsigned PIX_W   = 15;
  localparam int unsigned WORDS_W = 16;
  localparam int unsigned COL_W   = 8;
  localparam int unsigned ROW_W   = 7;
  localparam int unsigned OX_W    = 10;
  localparam int unsigned SCALE_W = 4;
  localparam int unsigned DISP_W  = 11;
  localparam int unsigned X_W     = 13;  // origin_x + column*scale, up to 4848
  localparam int unsigned Y_W     = 12;  // origin_y + row*scale, up to 2928
  localparam int unsigned COLOR_W = 32;
  localparam int unsigned DIV_CNT_W = $clog2(PIX_W + 1);

  // Configuration port
  localparam int unsigned CFG_AW = 5;
  localparam int unsigned CFG_DW = 32;

  localparam logic [DISP_W-1:0] DISP_MAX = 11'd1024;

  // Register reset values
  localparam logic [COL_W-1:0]   RST_SPRITE_W = 8'd64;
  localparam logic [ROW_W-1:0]   RST_SPRITE_H = 7'd64;
  localparam logic [SCALE_W-1:0] RST_SCALE    = 4'd1;
  localparam logic [DISP_W-1:0]  RST_DISP_W   = 11'd960;
  localparam logic [DISP_W-1:0]  RST_DISP_H   = 11'd544;

  // Input op codes
  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  typedef enum logic [1:0] {
    KIND_DRAW  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ABORT = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    REG_SPRITE_W = 3'd0,
    REG_SPRITE_H = 3'd1,
    REG_ORIGIN_X = 3'd2,
    REG_ORIGIN_Y = 3'd3,
    REG_SCALE    = 3'd4,
    REG_DISP_W   = 3'd5,
    REG_DISP_H   = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [COL_W-1:0]   sprite_width;
    logic [ROW_W-1:0]   sprite_height;
    logic [OX_W-1:0]    origin_x;
    logic [OX_W-1:0]    origin_y;
    logic [SCALE_W-1:0] scale;
    logic [DISP_W-1:0]  display_width;
    logic [DISP_W-1:0]  display_height;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic prep;
    logic eval;
    logic skip_end;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_div;
    logic eval_result;
    logic div_busy;
    logic skip_result;
    logic out_free;
  } stat_t;

  // RGB565 to 0xAABBGGRR with bit replication
  function automatic logic [COLOR_W-1:0] widen565(input logic [15:0] p);
    logic [4:0] r;
    logic [5:0] g;
    logic [4:0] b;
    r = p[15:11];
    g = p[10:5];
    b = p[4:0];
    return {8'hff, b, b[4:2], g, g[5:4], r, r[4:2]};
  endfunction

endpackage

`default_nettype wire

[rtl/core/rlesd_in_if.sv]
`default_nettype none

interface rlesd_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink (input valid, input op, input value, output ready);
endinterface

`default_nettype wire

[rtl/core/rlesd_out_if.sv]
`default_nettype none

interface rlesd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [9:0]  rect_x;
  logic [9:0]  rect_y;
  logic [3:0]  rect_width;
  logic [3:0]  rect_height;
  logic [31:0] color;
  logic        last;

  modport source (
    output valid, output kind, output rect_x, output rect_y, output rect_width,
    output rect_height, output color, output last, input ready
  );
  modport sink (
    input valid, input kind, input rect_x, input rect_y, input rect_width,
    input rect_height, input color, input last, output ready
  );
endinterface

`default_nettype wire

[rtl/core/rle_rgb565_sprite_decoder_top.sv]
// Run-length RGB565 sprite decoder.
// in_i carries requests: op 0 opens a frame with value as its word count,
// op 1 passes one frame word (a run token or an RGB565 literal).
// out_o carries at most one result per request: a clipped fill rectangle
// with an ABGR8888 color, a frame-done marker or a frame-abort marker;
// last marks the result that closes the frame.
// The APB port holds sprite size, origin, scale and display size; the
// registers are read live while a frame runs.
// Each request passes from idle through prep and eval and back to idle, and
// through emit when it yields a result. A transparent-run token also passes
// through div and skip_end: the pixel index is divided by sprite_width in a
// bit-serial divider, one quotient bit per cycle.
// One request is processed at a time; the next is taken as soon as the
// controller returns to idle, even while a result waits in the output
// register. A stalled receiver holds the result; if a second result is due
// before the first is taken, the controller waits and input stays blocked.
// Reset clears all frame state, empties the output register and restores
// register defaults (64x64 sprite, scale 1, 960x544 display).
`default_nettype none

module rle_rgb565_sprite_decoder_top #(
  parameter int unsigned PIXEL_LIMIT = 32768
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  rlesd_in_if.sink                       in_i,
  rlesd_out_if.source                    out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rlesd_pkg::CFG_AW-1:0]   paddr,
  input  logic [rlesd_pkg::CFG_DW-1:0]   pwdata,
  output logic [rlesd_pkg::CFG_DW-1:0]   prdata,
  output logic                           pready
);

  rlesd_pkg::cfg_t  cfg;
  rlesd_pkg::cmd_t  cmd;
  rlesd_pkg::stat_t stat;

  rlesd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rlesd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rlesd_dp #(
    .PIXEL_LIMIT (PIXEL_LIMIT)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .in_op_i           (in_i.op),
    .in_value_i        (in_i.value),
    .out_ready_i       (out_o.ready),
    .out_valid_o       (out_o.valid),
    .out_kind_o        (out_o.kind),
    .out_rect_x_o      (out_o.rect_x),
    .out_rect_y_o      (out_o.rect_y),
    .out_rect_width_o  (out_o.rect_width),
    .out_rect_height_o (out_o.rect_height),
    .out_color_o       (out_o.color),
    .out_last_o        (out_o.last)
  );

endmodule

`default_nettype wire

[rtl/core/rlesd_cfg.sv]
`default_nettype none

module rlesd_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rlesd_pkg::CFG_AW-1:0]      paddr,
  input  logic [rlesd_pkg::CFG_DW-1:0]      pwdata,
  output logic [rlesd_pkg::CFG_DW-1:0]      prdata,
  output logic                              pready,
  output rlesd_pkg::cfg_t                   cfg_o
);

  rlesd_pkg::cfg_t     cfg_q, cfg_d;
  rlesd_pkg::reg_idx_e idx;
  logic                wr_en;

  assign idx    = rlesd_pkg::reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        rlesd_pkg::REG_SPRITE_W: cfg_d.sprite_width   = pwdata[7:0];
        rlesd_pkg::REG_SPRITE_H: cfg_d.sprite_height  = pwdata[6:0];
        rlesd_pkg::REG_ORIGIN_X: cfg_d.origin_x       = pwdata[9:0];
        rlesd_pkg::REG_ORIGIN_Y: cfg_d.origin_y       = pwdata[9:0];
        rlesd_pkg::REG_SCALE:    cfg_d.scale          = pwdata[3:0];
        rlesd_pkg::REG_DISP_W:   cfg_d.display_width  = pwdata[10:0];
        rlesd_pkg::REG_DISP_H:   cfg_d.display_height = pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sprite_width   <= rlesd_pkg::RST_SPRITE_W;
      cfg_q.sprite_height  <= rlesd_pkg::RST_SPRITE_H;
      cfg_q.origin_x       <= '0;
      cfg_q.origin_y       <= '0;
      cfg_q.scale          <= rlesd_pkg::RST_SCALE;
      cfg_q.display_width  <= rlesd_pkg::RST_DISP_W;
      cfg_q.display_height <= rlesd_pkg::RST_DISP_H;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      rlesd_pkg::REG_SPRITE_W: prdata = 32'(cfg_q.sprite_width);
      rlesd_pkg::REG_SPRITE_H: prdata = 32'(cfg_q.sprite_height);
      rlesd_pkg::REG_ORIGIN_X: prdata = 32'(cfg_q.origin_x);
      rlesd_pkg::REG_ORIGIN_Y: prdata = 32'(cfg_q.origin_y);
      rlesd_pkg::REG_SCALE:    prdata = 32'(cfg_q.scale);
      rlesd_pkg::REG_DISP_W:   prdata = 32'(cfg_q.display_width);
      rlesd_pkg::REG_DISP_H:   prdata = 32'(cfg_q.display_height);
      default:                 prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/rlesd_div.sv]
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module rlesd_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [rlesd_pkg::PIX_W-1:0]    dividend_i,
  input  logic [rlesd_pkg::COL_W-1:0]    divisor_i,
  output logic                           busy_o,
  output logic [rlesd_pkg::PIX_W-1:0]    quotient_o,
  output logic [rlesd_pkg::COL_W-1:0]    remainder_o
);

  localparam int unsigned PW = rlesd_pkg::PIX_W;
  localparam int unsigned CW = rlesd_pkg::COL_W;
  localparam int unsigned NW = rlesd_pkg::DIV_CNT_W;

  logic [NW-1:0] cnt_q, cnt_d;
  logic [PW-1:0] quo_q, quo_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [CW-1:0] dvs_q, dvs_d;
  logic [CW:0]   trial;

  assign busy_o      = (cnt_q != '0);
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

  // Shift in next dividend bit, subtract when it fits
  always_comb begin
    trial = {rem_q, quo_q[PW-1]};
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    if (start_i) begin
      cnt_d = NW'(PW);
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (busy_o) begin
      cnt_d = cnt_q - 1'b1;
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = CW'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[PW-2:0], 1'b1};
      end else begin
        rem_d = trial[CW-1:0];
        quo_d = {quo_q[PW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

endmodule

`default_nettype wire

[rtl/core/rlesd_dp.sv]
`default_nettype none

module rlesd_dp #(
  parameter int unsigned PIXEL_LIMIT = 32768
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rlesd_pkg::cfg_t       cfg_i,
  input  rlesd_pkg::cmd_t       cmd_i,
  output rlesd_pkg::stat_t      stat_o,
  input  logic                  in_op_i,
  input  logic [15:0]           in_value_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [1:0]            out_kind_o,
  output logic [9:0]            out_rect_x_o,
  output logic [9:0]            out_rect_y_o,
  output logic [3:0]            out_rect_width_o,
  output logic [3:0]            out_rect_height_o,
  output logic [31:0]           out_color_o,
  output logic                  out_last_o
);

  localparam int unsigned PW = rlesd_pkg::PIX_W;
  localparam int unsigned WW = rlesd_pkg::WORDS_W;
  localparam int unsigned CW = rlesd_pkg::COL_W;
  localparam int unsigned RW = rlesd_pkg::ROW_W;
  localparam int unsigned XW = rlesd_pkg::X_W;
  localparam int unsigned YW = rlesd_pkg::Y_W;
  localparam int unsigned DW = rlesd_pkg::DISP_W;

  // Frame state
  logic          active_q, active_d;
  logic [PW-1:0] pix_q, pix_d;
  logic [WW-1:0] words_q, words_d;
  logic [PW-1:0] lit_q, lit_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  // Request and precomputed operands
  logic          op_q;
  logic [15:0]   val_q;
  logic [PW-1:0] pcnt_q;
  logic [XW-1:0] x_q;
  logic [YW-1:0] y_q;

  // Pending result
  rlesd_pkg::kind_e res_kind_q, res_kind_d;
  logic [9:0]    res_x_q, res_x_d, res_y_q, res_y_d;
  logic [3:0]    res_w_q, res_w_d, res_h_q, res_h_d;
  logic [31:0]   res_color_q, res_color_d;
  logic          res_last_q, res_last_d;

  // Output register
  logic          out_valid_q, out_valid_d;
  logic [1:0]    out_kind_q;
  logic [9:0]    out_x_q, out_y_q;
  logic [3:0]    out_w_q, out_h_q;
  logic [31:0]   out_color_q;
  logic          out_last_q;

  // Eval intermediates
  logic [DW-1:0] dw, dh, x_room, y_room;
  logic          x_ok, y_ok, draw;
  logic [3:0]    clip_w, clip_h;
  logic [WW-1:0] words_dec;
  logic [PW-1:0] lit_dec, pix_inc, count, pix_room, pix_skip;
  logic          col_wrap, tok_bad, lit_done, limit_bad, skip_go, eval_res, skip_res;

  // Divider
  logic          div_busy;
  logic [PW-1:0] div_quo;
  logic [CW-1:0] div_rem;

  rlesd_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (skip_go),
    .dividend_i  (pix_skip),
    .divisor_i   (cfg_i.sprite_width),
    .busy_o      (div_busy),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Clip and bookkeeping terms
  always_comb begin
    dw = (cfg_i.display_width > rlesd_pkg::DISP_MAX) ? rlesd_pkg::DISP_MAX
                                                     : cfg_i.display_width;
    dh = (cfg_i.display_height > rlesd_pkg::DISP_MAX) ? rlesd_pkg::DISP_MAX
                                                      : cfg_i.display_height;
    x_ok   = x_q < XW'(dw);
    y_ok   = y_q < YW'(dh);
    x_room = DW'(XW'(dw) - x_q);
    y_room = DW'(YW'(dh) - y_q);
    clip_w = (DW'(cfg_i.scale) > x_room) ? x_room[3:0] : cfg_i.scale;
    clip_h = (DW'(cfg_i.scale) > y_room) ? y_room[3:0] : cfg_i.scale;
    draw   = x_ok && y_ok && (clip_w != '0) && (clip_h != '0);

    words_dec = words_q - 1'b1;
    lit_dec   = lit_q - 1'b1;
    pix_inc   = pix_q + 1'b1;
    col_wrap  = ({1'b0, col_q} + 9'd1) >= {1'b0, cfg_i.sprite_width};
    lit_done  = (words_dec == '0) || ((lit_dec == '0) && (pix_inc >= pcnt_q));

    count     = val_q[PW-1:0];
    pix_room  = pcnt_q - pix_q;
    tok_bad   = (count == '0) || (pix_q >= pcnt_q) || (count > pix_room);
    pix_skip  = pix_q + count;
    limit_bad = 32'(pcnt_q) >= PIXEL_LIMIT;

    skip_go = cmd_i.eval && (op_q == rlesd_pkg::OP_DATA) && active_q &&
              (lit_q == '0) && !tok_bad && val_q[15];
    skip_res = (words_q == '0) || (pix_q >= pcnt_q);
  end

  // Frame state update
  always_comb begin
    active_d    = active_q;
    pix_d       = pix_q;
    words_d     = words_q;
    lit_d       = lit_q;
    col_d       = col_q;
    row_d       = row_q;
    res_kind_d  = res_kind_q;
    res_x_d     = res_x_q;
    res_y_d     = res_y_q;
    res_w_d     = res_w_q;
    res_h_d     = res_h_q;
    res_color_d = res_color_q;
    res_last_d  = res_last_q;
    eval_res    = 1'b0;

    if (cmd_i.eval) begin
      // Default result: frame end with zeroed fields
      res_x_d     = '0;
      res_y_d     = '0;
      res_w_d     = '0;
      res_h_d     = '0;
      res_color_d = '0;
      res_last_d  = 1'b1;
      if (op_q == rlesd_pkg::OP_BEGIN) begin
        active_d = 1'b1;
        pix_d    = '0;
        words_d  = val_q;
        lit_d    = '0;
        col_d    = '0;
        row_d    = '0;
        if ((cfg_i.scale == '0) || limit_bad) begin
          eval_res   = 1'b1;
          res_kind_d = rlesd_pkg::KIND_ABORT;
          active_d   = 1'b0;
        end else if ((val_q == '0) || (pcnt_q == '0)) begin
          eval_res   = 1'b1;
          res_kind_d = rlesd_pkg::KIND_DONE;
          active_d   = 1'b0;
        end
      end else if (active_q) begin
        words_d = words_dec;
        if (lit_q != '0) begin
          // Literal pixel
          lit_d = lit_dec;
          pix_d = pix_inc;
          if (col_wrap) begin
            col_d = '0;
            row_d = row_q + 1'b1;
          end else begin
            col_d = col_q + 1'b1;
          end
          if (draw) begin
            eval_res    = 1'b1;
            res_kind_d  = rlesd_pkg::KIND_DRAW;
            res_x_d     = x_q[9:0];
            res_y_d     = y_q[9:0];
            res_w_d     = clip_w;
            res_h_d     = clip_h;
            res_color_d = rlesd_pkg::widen565(val_q);
            res_last_d  = lit_done;
          end else if (lit_done) begin
            eval_res   = 1'b1;
            res_kind_d = rlesd_pkg::KIND_DONE;
          end
          if (lit_done) begin
            active_d = 1'b0;
            lit_d    = '0;
          end
        end else if (tok_bad) begin
          eval_res   = 1'b1;
          res_kind_d = rlesd_pkg::KIND_ABORT;
          active_d   = 1'b0;
        end else if (val_q[15]) begin
          // Transparent run; position comes from the divider
          pix_d = pix_skip;
        end else if (WW'(count) > words_dec) begin
          eval_res   = 1'b1;
          res_kind_d = rlesd_pkg::KIND_ABORT;
          active_d   = 1'b0;
        end else begin
          lit_d = count;
        end
      end
    end

    if (cmd_i.skip_end) begin
      col_d = div_rem;
      row_d = div_quo[RW-1:0];
      if (skip_res) begin
        active_d    = 1'b0;
        res_kind_d  = rlesd_pkg::KIND_DONE;
        res_x_d     = '0;
        res_y_d     = '0;
        res_w_d     = '0;
        res_h_d     = '0;
        res_color_d = '0;
        res_last_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      pix_q       <= '0;
      words_q     <= '0;
      lit_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      pix_q       <= pix_d;
      words_q     <= words_d;
      lit_q       <= lit_d;
      col_q       <= col_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request capture, operand prep, result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= in_op_i;
      val_q <= in_value_i;
    end
    if (cmd_i.prep) begin
      pcnt_q <= PW'(PW'(cfg_i.sprite_width) * PW'(cfg_i.sprite_height));
      x_q    <= XW'(cfg_i.origin_x) + XW'(col_q) * XW'(cfg_i.scale);
      y_q    <= YW'(cfg_i.origin_y) + YW'(row_q) * YW'(cfg_i.scale);
    end
    res_kind_q  <= res_kind_d;
    res_x_q     <= res_x_d;
    res_y_q     <= res_y_d;
    res_w_q     <= res_w_d;
    res_h_q     <= res_h_d;
    res_color_q <= res_color_d;
    res_last_q  <= res_last_d;
    if (cmd_i.emit) begin
      out_kind_q  <= res_kind_q;
      out_x_q     <= res_x_q;
      out_y_q     <= res_y_q;
      out_w_q     <= res_w_q;
      out_h_q     <= res_h_q;
      out_color_q <= res_color_q;
      out_last_q  <= res_last_q;
    end
  end

  // Output valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign stat_o.need_div    = skip_go;
  assign stat_o.eval_result = eval_res;
  assign stat_o.div_busy    = div_busy;
  assign stat_o.skip_result = skip_res;
  assign stat_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o       = out_valid_q;
  assign out_kind_o        = out_kind_q;
  assign out_rect_x_o      = out_x_q;
  assign out_rect_y_o      = out_y_q;
  assign out_rect_width_o  = out_w_q;
  assign out_rect_height_o = out_h_q;
  assign out_color_o       = out_color_q;
  assign out_last_o        = out_last_q;

endmodule

`default_nettype wire

[rtl/core/rlesd_ctrl.sv]
`default_nettype none

module rlesd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rlesd_pkg::stat_t stat_i,
  output rlesd_pkg::cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_PREP     = 6'b000010,
    S_EVAL     = 6'b000100,
    S_DIV      = 6'b001000,
    S_SKIP_END = 6'b010000,
    S_EMIT     = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        if (stat_i.need_div) begin
          state_d = S_DIV;
        end else if (stat_i.eval_result) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        if (!stat_i.div_busy) begin
          state_d = S_SKIP_END;
        end
      end
      S_SKIP_END: begin
        cmd_o.skip_end = 1'b1;
        state_d = stat_i.skip_result ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/rlesd_checker.sv]
`default_nettype none

module rlesd_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  out_kind_i,
  input  logic [9:0]  out_rect_x_i,
  input  logic [9:0]  out_rect_y_i,
  input  logic [3:0]  out_rect_width_i,
  input  logic [3:0]  out_rect_height_i,
  input  logic [31:0] out_color_i,
  input  logic        out_last_i
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_kind_i) &&
      $stable(out_rect_x_i) && $stable(out_rect_y_i) &&
      $stable(out_rect_width_i) && $stable(out_rect_height_i) &&
      $stable(out_color_i) && $stable(out_last_i))
    else $error("result changed while stalled");

  // One request at a time: no accept on the cycle after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after accept");

  // Done and abort markers carry zero fields and close the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i != rlesd_pkg::KIND_DRAW) |->
      out_last_i && (out_rect_x_i == '0) && (out_rect_y_i == '0) &&
      (out_rect_width_i == '0) && (out_rect_height_i == '0) &&
      (out_color_i == '0))
    else $error("frame marker with nonzero fields");

  // A drawn rectangle is opaque and not empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == rlesd_pkg::KIND_DRAW) |->
      (out_color_i[31:24] == 8'hff) && (out_rect_width_i != '0) &&
      (out_rect_height_i != '0))
    else $error("bad draw rectangle");

endmodule

bind rle_rgb565_sprite_decoder_top rlesd_checker u_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_kind_i        (out_o.kind),
  .out_rect_x_i      (out_o.rect_x),
  .out_rect_y_i      (out_o.rect_y),
  .out_rect_width_i  (out_o.rect_width),
  .out_rect_height_i (out_o.rect_height),
  .out_color_i       (out_o.color),
  .out_last_i        (out_o.last)
);

`default_nettype wire

[bench/rle_rgb565_sprite_decoder_top_test.sv]
`default_nettype none

module rle_rgb565_sprite_decoder_top_test;
  import rlesd_pkg::*;

  localparam int unsigned PIXEL_CAP     = 32768;
  localparam int unsigned SETTLE_CYCLES = 32;
  localparam int unsigned RUN_LIMIT     = 4_000_000;
  localparam int unsigned PHASES        = 16;
  localparam int unsigned PHASE_ITEMS   = 75;

  // One expected output: a fill rectangle or an end-of-frame marker
  typedef struct packed {
    kind_e       kind;
    logic [9:0]  x;
    logic [9:0]  y;
    logic [3:0]  w;
    logic [3:0]  h;
    logic [31:0] color;
    logic        last;
  } rect_cmd_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [CFG_DW-1:0]   pwdata;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  rlesd_in_if  in_bus ();
  rlesd_out_if out_bus ();

  rle_rgb565_sprite_decoder_top #(
    .PIXEL_LIMIT(PIXEL_CAP)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Shadow registers and decoder state
  cfg_t        cfg_now;
  logic        in_frame;
  logic [14:0] pix_pos;
  logic [15:0] words_rem;
  logic [14:0] lits_rem;
  logic [7:0]  src_col;
  logic [6:0]  src_row;

  rect_cmd_t   rects_due[$];
  int unsigned mismatches;
  int unsigned requests_sent;
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop
  initial begin
    #(RUN_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // RGB565 -> 0xAABBGGRR, low bits filled from the top bits
  function automatic logic [31:0] rgb565_to_abgr(input logic [15:0] p);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r = {p[15:11], p[15:13]};
    g = {p[10:5], p[10:9]};
    b = {p[4:0], p[4:2]};
    return {8'hff, b, g, r};
  endfunction

  function automatic rect_cmd_t close_frame(input kind_e k);
    rect_cmd_t c;
    c = '0;
    c.kind = k;
    c.last = 1'b1;
    in_frame = 1'b0;
    lits_rem = '0;
    return c;
  endfunction

  // Decoder prediction for one accepted request; returns 1 when it yields an output
  function automatic bit decode_word(input logic op, input logic [15:0] value,
                                     output rect_cmd_t cmd);
    int unsigned sw, sh, ox, oy, sc, npix, dw, dh, x, y, w, h, cnt;
    bit draw, done;
    sw = cfg_now.sprite_width;
    sh = cfg_now.sprite_height;
    ox = cfg_now.origin_x;
    oy = cfg_now.origin_y;
    sc = cfg_now.scale;
    npix = sw * sh;
    cmd = '0;

    if (op == OP_BEGIN) begin
      in_frame = 1'b1;
      pix_pos = '0;
      words_rem = value;
      lits_rem = '0;
      src_col = '0;
      src_row = '0;
      if (sc == 0 || npix >= PIXEL_CAP) begin
        cmd = close_frame(KIND_ABORT);
        return 1'b1;
      end
      if (value == 0 || npix == 0) begin
        cmd = close_frame(KIND_DONE);
        return 1'b1;
      end
      return 1'b0;
    end

    if (!in_frame) return 1'b0;
    words_rem = words_rem - 16'd1;

    // Literal pixel: one scaled rectangle, clipped at right and bottom
    if (lits_rem != 0) begin
      dw = cfg_now.display_width > 1024 ? 1024 : cfg_now.display_width;
      dh = cfg_now.display_height > 1024 ? 1024 : cfg_now.display_height;
      x = ox + src_col * sc;
      y = oy + src_row * sc;
      w = sc;
      h = sc;
      draw = x < dw && y < dh;
      if (draw) begin
        if (w > dw - x) w = dw - x;
        if (h > dh - y) h = dh - y;
        if (w == 0 || h == 0) draw = 1'b0;
      end
      lits_rem = lits_rem - 15'd1;
      pix_pos = pix_pos + 15'd1;
      if (src_col + 1 >= sw) begin
        src_col = '0;
        src_row = src_row + 7'd1;
      end else begin
        src_col = src_col + 8'd1;
      end
      done = words_rem == 0 || (lits_rem == 0 && pix_pos >= npix);
      if (!draw) begin
        if (done) begin
          cmd = close_frame(KIND_DONE);
          return 1'b1;
        end
        return 1'b0;
      end
      cmd.kind = KIND_DRAW;
      cmd.x = x[9:0];
      cmd.y = y[9:0];
      cmd.w = w[3:0];
      cmd.h = h[3:0];
      cmd.color = rgb565_to_abgr(value);
      cmd.last = done;
      if (done) begin
        in_frame = 1'b0;
        lits_rem = '0;
      end
      return 1'b1;
    end

    // Run token
    cnt = value[14:0];
    if (cnt == 0 || pix_pos >= npix || cnt > npix - pix_pos) begin
      cmd = close_frame(KIND_ABORT);
      return 1'b1;
    end
    if (value[15]) begin
      pix_pos = pix_pos + cnt;
      if (sw != 0) begin
        src_col = pix_pos % sw;
        src_row = pix_pos / sw;
      end
      if (words_rem == 0 || pix_pos >= npix) begin
        cmd = close_frame(KIND_DONE);
        return 1'b1;
      end
      return 1'b0;
    end
    if (cnt > words_rem) begin
      cmd = close_frame(KIND_ABORT);
      return 1'b1;
    end
    lits_rem = cnt;
    return 1'b0;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endfunction

  // Output checker
  always @(posedge clk_i) begin : check_outputs
    rect_cmd_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (rects_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected output, expected none actual kind %0d x %0d y %0d",
                 $time, out_bus.kind, out_bus.rect_x, out_bus.rect_y);
      end else begin
        want = rects_due.pop_front();
        check_field("kind", want.kind, out_bus.kind);
        check_field("rect_x", want.x, out_bus.rect_x);
        check_field("rect_y", want.y, out_bus.rect_y);
        check_field("rect_width", want.w, out_bus.rect_width);
        check_field("rect_height", want.h, out_bus.rect_height);
        check_field("color", want.color, out_bus.color);
        check_field("last", want.last, out_bus.last);
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk_i) begin
    out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Send one request, with random idle cycles ahead of it
  task automatic send_word(input logic op, input logic [15:0] value);
    rect_cmd_t cmd;
    @(negedge clk_i);
    while ($urandom_range(99) < send_gap_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.op <= op;
    in_bus.value <= value;
    do begin
      @(posedge clk_i);
    end while (!in_bus.ready);
    if (op == OP_BEGIN || in_frame) requests_sent++;
    if (decode_word(op, value, cmd)) rects_due.push_back(cmd);
  endtask

  // Stop sending and let every pending output and run come out
  task automatic wait_drained();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (rects_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] data);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    case (idx)
      REG_SPRITE_W: cfg_now.sprite_width = data[COL_W-1:0];
      REG_SPRITE_H: cfg_now.sprite_height = data[ROW_W-1:0];
      REG_ORIGIN_X: cfg_now.origin_x = data[OX_W-1:0];
      REG_ORIGIN_Y: cfg_now.origin_y = data[OX_W-1:0];
      REG_SCALE:    cfg_now.scale = data[SCALE_W-1:0];
      REG_DISP_W:   cfg_now.display_width = data[DISP_W-1:0];
      REG_DISP_H:   cfg_now.display_height = data[DISP_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Unused upper bits carry noise; they must be dropped
  task automatic load_config(input cfg_t c);
    write_reg(REG_SPRITE_W, {24'($urandom), c.sprite_width});
    write_reg(REG_SPRITE_H, {25'($urandom), c.sprite_height});
    write_reg(REG_ORIGIN_X, {22'($urandom), c.origin_x});
    write_reg(REG_ORIGIN_Y, {22'($urandom), c.origin_y});
    write_reg(REG_SCALE, {28'($urandom), c.scale});
    write_reg(REG_DISP_W, {21'($urandom), c.display_width});
    write_reg(REG_DISP_H, {21'($urandom), c.display_height});
  endtask

  // Mostly small sprites near the display edges; phases 1 and 2 pin the extremes
  function automatic cfg_t pick_config(input int unsigned phase);
    cfg_t c;
    int unsigned p;
    p = $urandom_range(99);
    c.sprite_width = p < 4 ? 8'd0 : p < 12 ? 8'd255 : p < 20 ? 8'd1 :
                     8'($urandom_range(2, 12));
    p = $urandom_range(99);
    c.sprite_height = p < 4 ? 7'd0 : p < 10 ? 7'd127 : p < 20 ? 7'd1 :
                      7'($urandom_range(2, 8));
    p = $urandom_range(99);
    c.origin_x = p < 20 ? 10'd0 : p < 35 ? 10'd1023 :
                 p < 65 ? 10'($urandom_range(900, 1023)) : 10'($urandom_range(0, 200));
    p = $urandom_range(99);
    c.origin_y = p < 20 ? 10'd0 : p < 35 ? 10'd1023 :
                 p < 65 ? 10'($urandom_range(480, 1023)) : 10'($urandom_range(0, 200));
    p = $urandom_range(99);
    c.scale = p < 5 ? 4'd0 : p < 20 ? 4'd15 : 4'($urandom_range(1, 14));
    p = $urandom_range(99);
    c.display_width = p < 4 ? 11'd0 : p < 10 ? 11'd1 : p < 25 ? 11'd1024 :
                      p < 40 ? 11'($urandom_range(1025, 2047)) :
                      11'($urandom_range(16, 1024));
    p = $urandom_range(99);
    c.display_height = p < 4 ? 11'd0 : p < 10 ? 11'd1 : p < 25 ? 11'd1024 :
                       p < 40 ? 11'($urandom_range(1025, 2047)) :
                       11'($urandom_range(16, 1024));
    if (phase == 1) begin
      c.sprite_width = 8'd1;
      c.sprite_height = 7'd1;
      c.origin_x = '0;
      c.origin_y = '0;
      c.scale = 4'd1;
      c.display_width = 11'd1;
      c.display_height = 11'd1;
    end else if (phase == 2) begin
      c.sprite_width = 8'd255;
      c.sprite_height = 7'd127;
      c.origin_x = 10'd1023;
      c.origin_y = 10'd1023;
      c.scale = 4'd15;
      c.display_width = 11'd1024;
      c.display_height = 11'd1024;
    end
    return c;
  endfunction

  // One run-length frame with random runs and literals, sometimes damaged
  task automatic send_sprite_frame();
    logic [15:0] words[$];
    int unsigned npix, left, n, target, hdr, p, k;
    npix = cfg_now.sprite_width * cfg_now.sprite_height;
    left = npix != 0 ? npix : $urandom_range(1, 4);
    target = $urandom_range(3, 30);
    while (words.size() < target && left != 0) begin
      n = $urandom_range(1, left < 6 ? left : 6);
      if ($urandom_range(99) < 35) begin
        if ($urandom_range(99) < 15) n = left;
        words.push_back({1'b1, n[14:0]});
      end else begin
        words.push_back({1'b0, n[14:0]});
        repeat (n) words.push_back(16'($urandom_range(65535)));
      end
      left -= n;
    end
    hdr = words.size();
    p = $urandom_range(99);
    if (p < 70) begin
      // well formed
    end else if (p < 80) begin
      hdr = $urandom_range(99) < 20 ? 16'hffff : hdr + $urandom_range(1, 3);
    end else if (p < 90) begin
      hdr = $urandom_range(0, hdr);
    end else begin
      k = $urandom_range(0, words.size() - 1);
      case ($urandom_range(3))
        0: words[k] = 16'h0000;
        1: words[k] = 16'h8000;
        2: words[k] = 16'hffff;
        default: words[k] = 16'h7fff;
      endcase
    end
    if ($urandom_range(99) < 5) send_word(OP_DATA, 16'($urandom_range(65535)));
    send_word(OP_BEGIN, hdr[15:0]);
    foreach (words[i]) begin
      if ($urandom_range(199) == 0) wait_drained();
      send_word(OP_DATA, words[i]);
    end
  endtask

  // Reset defaults: two literals, a skip to the next row, then a literal run
  // longer than the words left
  task automatic test_default_frame();
    send_word(OP_BEGIN, 16'd5);
    send_word(OP_DATA, 16'h0002);
    send_word(OP_DATA, 16'hffff);
    send_word(OP_DATA, 16'h0000);
    send_word(OP_DATA, 16'h803e);
    send_word(OP_DATA, 16'h0001);
  endtask

  // Begin with zero scale, zero words, zero width; data while idle; bad tokens;
  // begin while a frame is open
  task automatic test_frame_open_and_abort();
    wait_drained();
    write_reg(REG_SCALE, 32'd0);
    send_word(OP_BEGIN, 16'd3);
    wait_drained();
    write_reg(REG_SCALE, 32'd2);
    send_word(OP_BEGIN, 16'd0);
    wait_drained();
    write_reg(REG_SPRITE_W, 32'd0);
    send_word(OP_BEGIN, 16'd4);
    send_word(OP_DATA, 16'h1234);
    wait_drained();
    write_reg(REG_SPRITE_W, 32'd3);
    write_reg(REG_SPRITE_H, 32'd2);
    send_word(OP_BEGIN, 16'd10);
    send_word(OP_DATA, 16'h8000);
    send_word(OP_BEGIN, 16'd10);
    send_word(OP_DATA, 16'h0001);
    send_word(OP_BEGIN, 16'd6);
    send_word(OP_DATA, 16'hffff);
    send_word(OP_BEGIN, 16'd2);
    send_word(OP_DATA, 16'h0005);
  endtask

  // Scale 15 at the bottom-right corner, oversize display registers; the final
  // literal falls off the display and closes the frame without a draw
  task automatic test_edge_clipping();
    cfg_t c;
    wait_drained();
    c.sprite_width = 8'd3;
    c.sprite_height = 7'd2;
    c.origin_x = 10'd1000;
    c.origin_y = 10'd1020;
    c.scale = 4'd15;
    c.display_width = 11'd2047;
    c.display_height = 11'd1030;
    load_config(c);
    send_word(OP_BEGIN, 16'd4);
    send_word(OP_DATA, 16'h0003);
    repeat (3) send_word(OP_DATA, 16'($urandom_range(65535)));
  endtask

  // Shrinking the sprite under an open frame makes the next token abort
  task automatic test_resize_mid_frame();
    wait_drained();
    send_word(OP_BEGIN, 16'd10);
    send_word(OP_DATA, 16'h8005);
    wait_drained();
    write_reg(REG_SPRITE_W, 32'd2);
    send_word(OP_DATA, 16'h0001);
  endtask

  // Random frames over several register settings and idle patterns
  task automatic test_random_frames();
    int unsigned phase, stop_at;
    for (phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      case (phase % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 56; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 56; end
        default: begin send_gap_pct = 16; recv_stall_pct = 16; end
      endcase
      load_config(pick_config(phase));
      stop_at = requests_sent + PHASE_ITEMS;
      while (requests_sent < stop_at) send_sprite_frame();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_bus.valid = 1'b0;
    in_bus.op = OP_BEGIN;
    in_bus.value = '0;
    out_bus.ready = 1'b0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    mismatches = 0;
    requests_sent = 0;

    // Register defaults and cleared frame state after reset
    cfg_now.sprite_width = RST_SPRITE_W;
    cfg_now.sprite_height = RST_SPRITE_H;
    cfg_now.origin_x = '0;
    cfg_now.origin_y = '0;
    cfg_now.scale = RST_SCALE;
    cfg_now.display_width = RST_DISP_W;
    cfg_now.display_height = RST_DISP_H;
    in_frame = 1'b0;
    pix_pos = '0;
    words_rem = '0;
    lits_rem = '0;
    src_col = '0;
    src_row = '0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_default_frame();
    test_frame_open_and_abort();
    test_edge_clipping();
    test_resize_mid_frame();
    test_random_frames();
    wait_drained();

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
rtl/core/rlesd_pkg.sv
rtl/core/rlesd_in_if.sv
rtl/core/rlesd_out_if.sv
rtl/core/rlesd_cfg.sv
rtl/core/rlesd_div.sv
rtl/core/rlesd_dp.sv
rtl/core/rlesd_ctrl.sv
rtl/core/rle_rgb565_sprite_decoder_top.sv
rtl/core/rlesd_checker.sv
bench/rle_rgb565_sprite_decoder_top_test.sv
